// ===== design/tkts_pkg.sv =====
// Shared constants, widths and controller/datapath handshake types for the token sampler.
`default_nettype none
package tkts_pkg;

  localparam int MAX_TOP_K = 64;
  localparam int MAX_VOCAB = 65536;

  localparam int PROB_W  = 16;
  localparam int INDEX_W = 16;
  localparam int TOPK_W  = 7;
  localparam int THR_W   = 17;
  localparam int NSIZE_W = 7;

  localparam int POS_W   = (MAX_TOP_K > 1) ? $clog2(MAX_TOP_K) : 1;
  localparam int NUM_W   = $clog2(MAX_TOP_K + 1);
  localparam int CNT_W   = $clog2(MAX_VOCAB + 1);
  localparam int SUM_W   = $clog2(MAX_TOP_K * (2 ** PROB_W - 1) + 1);
  localparam int SCALE_W = PROB_W + SUM_W;

  localparam int TOPK_RESET = 50;
  localparam int THR_RESET  = 65536;

  typedef enum logic {
    REG_TOP_K       = 1'b0,
    REG_TOP_P_THRESH = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic load_en;
    logic cut_step;
    logic mul;
    logic draw_step;
  } tkts_cmd_t;

  typedef struct packed {
    logic last_req;
    logic cut_last;
    logic draw_hit;
    logic slot_free;
  } tkts_status_t;

endpackage
`default_nettype wire

// ===== design/tkts_if.sv =====
// Stream interfaces for probability requests and sampled-token results.
`default_nettype none
interface tkts_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] prob;
  logic        last;
  logic [15:0] rand_fraction;

  modport source (output valid, output prob, output last, output rand_fraction, input ready);
  modport sink   (input valid, input prob, input last, input rand_fraction, output ready);
endinterface

interface tkts_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] token_index;
  logic [6:0]  nucleus_size;

  modport source (output valid, output token_index, output nucleus_size, input ready);
  modport sink   (input valid, input token_index, input nucleus_size, output ready);
endinterface
`default_nettype wire

// ===== design/top_k_top_p_token_sampler.sv =====
// Top level of the top-k / top-p token sampler.
//
//   channel   dir  payload                                    accepted when
//   in_item   in   prob[16], last[1], rand_fraction[16]       valid && ready
//   result    out  token_index[16], nucleus_size[7]           valid && ready
//   cfg       in   cfg_addr[1], cfg_data[17]                  cfg_we
//
// Ordinary elements are taken one per cycle while loading; each goes straight into the sorted list.
// The request marked last starts a walk of the whole list for the top-p cut, then
// the scaling multiply and a draw of one to n steps (n = nucleus size), ending at
// the chosen entry, all on the rotating candidate list; no request is taken
// meanwhile.
// Reset is synchronous; the candidate list needs no clearing.
// A stalled result holds the draw at its final step until the slot frees.
`default_nettype none
module top_k_top_p_token_sampler
  import tkts_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic             cfg_addr,
  input  wire logic [THR_W-1:0] cfg_data,
  tkts_in_if.sink               in_item,
  tkts_out_if.source            result
);

  tkts_cmd_t    cmd;
  tkts_status_t status;

  tkts_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  tkts_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .in_item  (in_item),
    .result   (result),
    .cmd      (cmd),
    .status   (status)
  );

endmodule
`default_nettype wire

// ===== design/tkts_ctrl.sv =====
// Sequencer for loading, the top-p cut pass, the scaling step and the draw pass.
`default_nettype none
module tkts_ctrl
  import tkts_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  tkts_status_t      status,
  output tkts_cmd_t         cmd
);

  typedef enum logic [1:0] {
    S_LOAD,
    S_CUT,
    S_MUL,
    S_DRAW
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_LOAD: begin
        cmd.load_en = 1'b1;
        if (status.last_req) begin
          state_next = S_CUT;
        end
      end
      S_CUT: begin
        cmd.cut_step = 1'b1;
        if (status.cut_last) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_next = S_DRAW;
      end
      S_DRAW: begin
        // A hit needs a free result slot; otherwise hold the list where it is.
        if (!status.draw_hit || status.slot_free) begin
          cmd.draw_step = 1'b1;
          if (status.draw_hit) begin
            state_next = S_LOAD;
          end
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ===== design/tkts_datapath.sv =====
// Sorted candidate list, configuration registers, running sums and result register.
`default_nettype none
module tkts_datapath
  import tkts_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic               cfg_addr,
  input  wire logic [THR_W-1:0]   cfg_data,
  tkts_in_if.sink                 in_item,
  tkts_out_if.source              result,
  input  tkts_cmd_t               cmd,
  output tkts_status_t            status
);

  logic [TOPK_W-1:0]  top_k;
  logic [THR_W-1:0]   top_p_threshold;

  logic [PROB_W-1:0]  best_prob  [MAX_TOP_K];
  logic [INDEX_W-1:0] best_index [MAX_TOP_K];
  logic [PROB_W-1:0]  best_prob_next  [MAX_TOP_K];
  logic [INDEX_W-1:0] best_index_next [MAX_TOP_K];
  logic [MAX_TOP_K-1:0] ge;

  logic [CNT_W-1:0]   loaded_count;
  logic [NUM_W-1:0]   k_lim;
  logic [PROB_W-1:0]  rand_q;
  logic [POS_W-1:0]   rot_cnt;
  logic               cut_active;
  logic [NUM_W-1:0]   n_cnt;
  logic [SUM_W-1:0]   sum;
  logic [SCALE_W-1:0] scaled;
  logic [SUM_W-1:0]   acc;
  logic [NUM_W-1:0]   draw_cnt;

  logic               take;
  logic               do_insert;
  logic [CNT_W-1:0]   count_after;
  logic [CNT_W-1:0]   k_eff;
  logic [CNT_W-1:0]   tk_w;
  logic               rotate;
  logic [SUM_W-1:0]   sum_new;
  logic [NUM_W-1:0]   n_new;
  logic [SUM_W-1:0]   acc_new;
  logic [NUM_W-1:0]   draw_new;

  assign in_item.ready = cmd.load_en;
  assign take          = in_item.valid && cmd.load_en;
  assign do_insert     = take && (loaded_count < CNT_W'(MAX_VOCAB));
  assign count_after   = do_insert ? loaded_count + 1'b1 : loaded_count;
  assign rotate        = cmd.cut_step || cmd.draw_step;

  // Effective K: zero acts as one, then limited by list depth and elements loaded.
  always_comb begin
    tk_w = (top_k == '0) ? CNT_W'(1) : CNT_W'(top_k);
    k_eff = tk_w;
    if (k_eff > CNT_W'(MAX_TOP_K)) begin
      k_eff = CNT_W'(MAX_TOP_K);
    end
    if (k_eff > count_after) begin
      k_eff = count_after;
    end
  end

  // Each cell keeps its entry while it equals or outranks the newcomer, otherwise it takes
  // the newcomer or its upper neighbor. During the walks the list rotates toward
  // cell zero so that the head is always read at one place.
  always_comb begin
    for (int j = 0; j < MAX_TOP_K; j++) begin
      ge[j] = (CNT_W'(j) < loaded_count) && (best_prob[j] >= in_item.prob);
    end
    for (int j = 0; j < MAX_TOP_K; j++) begin
      best_prob_next[j]  = best_prob[j];
      best_index_next[j] = best_index[j];
      if (rotate) begin
        best_prob_next[j]  = best_prob[(j + 1) % MAX_TOP_K];
        best_index_next[j] = best_index[(j + 1) % MAX_TOP_K];
      end else if (do_insert && !ge[j]) begin
        if (j == 0 || ge[(j == 0) ? 0 : j - 1]) begin
          best_prob_next[j]  = in_item.prob;
          best_index_next[j] = INDEX_W'(loaded_count);
        end else begin
          best_prob_next[j]  = best_prob[(j == 0) ? 0 : j - 1];
          best_index_next[j] = best_index[(j == 0) ? 0 : j - 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_TOP_K; j++) begin
      best_prob[j]  <= best_prob_next[j];
      best_index[j] <= best_index_next[j];
    end
  end

  assign sum_new  = sum + SUM_W'(best_prob[0]);
  assign n_new    = n_cnt + 1'b1;
  assign acc_new  = acc + SUM_W'(best_prob[0]);
  assign draw_new = draw_cnt + 1'b1;

  assign status.last_req  = in_item.valid && in_item.last;
  assign status.cut_last  = (rot_cnt == POS_W'(MAX_TOP_K - 1));
  assign status.draw_hit  = (scaled < {acc_new, {PROB_W{1'b0}}}) || (draw_new == n_cnt);
  assign status.slot_free = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      top_k           <= TOPK_W'(TOPK_RESET);
      top_p_threshold <= THR_W'(THR_RESET);
      loaded_count    <= '0;
      result.valid    <= 1'b0;
      cut_active      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_addr))
          REG_TOP_K:        top_k <= cfg_data[TOPK_W-1:0];
          REG_TOP_P_THRESH: top_p_threshold <= cfg_data;
          default: ;
        endcase
      end

      if (take && in_item.last) begin
        loaded_count <= '0;
        k_lim        <= NUM_W'(k_eff);
        rand_q       <= in_item.rand_fraction;
        rot_cnt      <= '0;
        cut_active   <= 1'b1;
        n_cnt        <= '0;
        sum          <= '0;
      end else if (do_insert) begin
        loaded_count <= count_after;
      end

      if (cmd.cut_step) begin
        rot_cnt <= rot_cnt + 1'b1;
        if (cut_active) begin
          sum   <= sum_new;
          n_cnt <= n_new;
          if ((32'(sum_new) >= 32'(top_p_threshold)) || (n_new == k_lim)) begin
            cut_active <= 1'b0;
          end
        end
      end

      if (cmd.mul) begin
        scaled   <= SCALE_W'(rand_q) * SCALE_W'(sum);
        acc      <= '0;
        draw_cnt <= '0;
      end

      if (cmd.draw_step) begin
        acc      <= acc_new;
        draw_cnt <= draw_new;
      end

      if (cmd.draw_step && status.draw_hit) begin
        result.valid        <= 1'b1;
        result.token_index  <= best_index[0];
        result.nucleus_size <= NSIZE_W'(n_cnt);
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== dv/top_k_top_p_token_sampler_tb.sv =====
// Self-checking testbench for the top-k / top-p token sampler.
`default_nettype none
module top_k_top_p_token_sampler_tb;
  import tkts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] prob;
    logic        last;
    logic [15:0] rand_fraction;
  } prob_req_t;

  typedef struct packed {
    logic [15:0] token_index;
    logic [6:0]  nucleus_size;
  } token_res_t;

  // One directed row: a request, an optional hand-typed expectation.
  typedef struct {
    prob_req_t  req;
    bit         typed;
    token_res_t res;
  } vec_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_addr = 1'b0;
  logic [THR_W-1:0] cfg_data = '0;

  tkts_in_if  in_item ();
  tkts_out_if result ();

  top_k_top_p_token_sampler uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .in_item(in_item.sink), .result(result.source)
  );

  always #6 clk = ~clk;

  // Predictor state.
  logic [15:0] cand_idx [MAX_TOP_K];
  logic [15:0] cand_prob[MAX_TOP_K];
  int unsigned seen_count;
  logic [6:0]  k_setting;
  logic [16:0] thr_setting;

  token_res_t sampled_q[$];
  int mismatches = 0;
  int results_seen = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_off = 1'b0;

  function automatic void predict_token(prob_req_t r);
    int unsigned used, pos, k, n;
    longint unsigned sum, acc, scaled;
    token_res_t t;
    if (seen_count < MAX_VOCAB) begin
      used = (seen_count < MAX_TOP_K) ? seen_count : MAX_TOP_K;
      pos = 0;
      while (pos < used && cand_prob[pos] >= r.prob) pos++;
      if (pos < MAX_TOP_K) begin
        for (int j = (used < MAX_TOP_K) ? used : MAX_TOP_K - 1; j > pos; j--) begin
          cand_idx[j]  = cand_idx[j-1];
          cand_prob[j] = cand_prob[j-1];
        end
        cand_idx[pos]  = seen_count[15:0];
        cand_prob[pos] = r.prob;
      end
      seen_count++;
    end
    if (!r.last) return;
    k = (k_setting == 0) ? 1 : k_setting;
    if (k > MAX_TOP_K) k = MAX_TOP_K;
    if (k > seen_count) k = seen_count;
    sum = 0;
    n = 0;
    while (n < k) begin
      sum += cand_prob[n];
      n++;
      if (sum >= thr_setting) break;
    end
    scaled = r.rand_fraction * sum;
    t.token_index = cand_idx[n-1];
    acc = 0;
    for (int i = 0; i < n; i++) begin
      acc += cand_prob[i];
      if (scaled < (acc << 16)) begin
        t.token_index = cand_idx[i];
        break;
      end
    end
    t.nucleus_size = n[6:0];
    sampled_q = {sampled_q, t};
    seen_count = 0;
  endfunction

  task automatic write_reg(cfg_reg_t addr, logic [16:0] val);
    cfg_we   <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (addr == REG_TOP_K) k_setting = val[6:0];
    else thr_setting = val;
  endtask

  // Drives one request and holds it until accepted; valid stays up for a back-to-back request.
  task automatic send_req(prob_req_t r);
    while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_item.valid <= 1'b0;
      @(posedge clk);
    end
    in_item.valid         <= 1'b1;
    in_item.prob          <= r.prob;
    in_item.last          <= r.last;
    in_item.rand_fraction <= r.rand_fraction;
    do @(posedge clk); while (!in_item.ready);
    predict_token(r);
  endtask

  task automatic go_idle();
    in_item.valid <= 1'b0;
    @(posedge clk);
    while (sampled_q.size() != 0) @(posedge clk);
    repeat (MAX_TOP_K + MAX_TOP_K + 8) @(posedge clk);
  endtask

  // Receiver: random stalls plus a long hold-off when asked.
  always @(posedge clk) begin
    if (rst || hold_off) result.ready <= 1'b0;
    else result.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && result.valid && result.ready) begin
      token_res_t got, want;
      got.token_index  = result.token_index;
      got.nucleus_size = result.nucleus_size;
      results_seen++;
      if (sampled_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d/%0d", got.token_index,
                                       got.nucleus_size);
      end else begin
        want = sampled_q.pop_front();
        if (got.token_index != want.token_index || got.nucleus_size != want.nucleus_size) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: token %0d exp %0d, nucleus %0d exp %0d", got.token_index,
                     want.token_index, got.nucleus_size, want.nucleus_size);
        end
      end
    end
  end

  function automatic prob_req_t mk(logic [15:0] p, logic l, logic [15:0] rf);
    prob_req_t r;
    r.prob = p;
    r.last = l;
    r.rand_fraction = rf;
    return r;
  endfunction

  function automatic vec_row_t row(logic [15:0] p, logic l, logic [15:0] rf, bit typed = 0,
                                   logic [15:0] ti = 0, logic [6:0] ns = 0);
    vec_row_t v;
    v.req = mk(p, l, rf);
    v.typed = typed;
    v.res.token_index = ti;
    v.res.nucleus_size = ns;
    return v;
  endfunction

  // Random distribution of the given length: uniform, small, extreme or power-of-two probabilities.
  task automatic random_dist(int len);
    logic [15:0] p;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(3, 0))
        0: p = 16'($urandom_range(65535, 0));
        1: p = 16'($urandom_range(255, 0));
        2: p = ($urandom_range(1, 0)) ? 16'hFFFF : 16'h0;
        default: p = 16'h1000 << $urandom_range(3, 0);
      endcase
      send_req(mk(p, i == len - 1, 16'($urandom_range(65535, 0))));
    end
  endtask

  task automatic random_phase(int items);
    int done_items;
    done_items = 0;
    while (done_items < items) begin
      int len;
      len = ($urandom_range(9, 0) == 0) ? $urandom_range(140, 60) : $urandom_range(12, 1);
      random_dist(len);
      done_items += len;
    end
  endtask

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    vec_row_t dir[$];
    in_item.valid <= 1'b0;
    in_item.prob <= '0;
    in_item.last <= 1'b0;
    in_item.rand_fraction <= '0;
    for (int i = 0; i < MAX_TOP_K; i++) begin
      cand_idx[i] = '0;
      cand_prob[i] = '0;
    end
    seen_count = 0;
    k_setting = TOPK_RESET;
    thr_setting = THR_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: single-element lists, extremes, ties, all-zero, zero threshold.
    dir = {dir, row(16'hFFFF, 1, 16'hFFFF, 1, 0, 1)};
    dir = {dir, row(16'h0000, 1, 16'h0000, 1, 0, 1)};
    dir = {dir, row(16'h0000, 0, 16'h0)};
    dir = {dir, row(16'h0000, 0, 16'h0)};
    dir = {dir, row(16'h0000, 1, 16'h1234)};   // all zero: last nucleus entry
    dir = {dir, row(16'h4000, 0, 16'h0)};
    dir = {dir, row(16'h4000, 0, 16'h0)};      // tie: earlier index first
    dir = {dir, row(16'h8000, 1, 16'h0, 1, 2, 3)};
    dir = {dir, row(16'h0001, 0, 16'h0)};
    dir = {dir, row(16'hFFFF, 0, 16'h0)};
    dir = {dir, row(16'h8000, 1, 16'hFFFF)};
    foreach (dir[i]) begin
      send_req(dir[i].req);
      if (dir[i].typed) begin
        sampled_q[sampled_q.size() - 1] = dir[i].res;
      end
    end
    go_idle();

    write_reg(REG_TOP_P_THRESH, 17'd0);           // nucleus is one entry
    write_reg(REG_TOP_K, 17'd0);
    send_req(mk(16'h0100, 0, 0));
    send_req(mk(16'h0200, 1, 16'hABCD));
    go_idle();
    write_reg(REG_TOP_K, 17'd127);
    write_reg(REG_TOP_P_THRESH, 17'h1FFFF);
    random_dist(70);
    go_idle();

    // Random phases over several settings and idling patterns.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 3)
        0: begin send_idle_pct = 8;  recv_idle_pct = 65; end
        1: begin send_idle_pct = 65; recv_idle_pct = 8;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (ph)
        0: begin write_reg(REG_TOP_K, 17'd1);  write_reg(REG_TOP_P_THRESH, 17'd65536); end
        1: begin write_reg(REG_TOP_K, 17'd64); write_reg(REG_TOP_P_THRESH, 17'd30000); end
        2: begin write_reg(REG_TOP_K, 17'd65); write_reg(REG_TOP_P_THRESH, 17'd0); end
        default: begin
          write_reg(REG_TOP_K, 17'($urandom_range(127, 0)));
          write_reg(REG_TOP_P_THRESH, 17'($urandom_range(131071, 0)));
        end
      endcase
      if (ph == 2) begin
        // Long receiver hold-off while requests keep coming.
        fork
          begin hold_off = 1'b1; repeat (600) @(posedge clk); hold_off = 1'b0; end
          random_phase(60);
        join
      end
      random_phase(250);
      go_idle();
    end

    $display("Ran directed cases and about 1600 random requests over a range of settings;");
    $display("%0d sampled tokens were checked.", results_seen);
    if (mismatches == 0 && sampled_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
